// ===== rtl/wsdf_pkg.sv =====
// Package for the frame deframer: shared types, event codes and widths.
// No dependencies; every other rtl file uses it.
package wsdf_pkg;

    localparam int LEN_W    = 17;  // frame length / max payload width
    localparam int QDEPTH   = 2;   // front-to-back queue depth
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCNT_W   = $clog2(QDEPTH + 1);

    localparam logic [3:0] OPC_CLOSE   = 4'h8;
    localparam logic [6:0] LEN7_EXT16  = 7'd126;
    localparam logic [6:0] LEN7_EXT64  = 7'd127;
    localparam logic [LEN_W-1:0] MAX_PAYLOAD_RST = 17'd65536;

    typedef enum logic [1:0] {
        EV_DATA  = 2'd0,
        EV_EMPTY = 2'd1,
        EV_CLOSE = 2'd2,
        EV_ERROR = 2'd3
    } event_t;

    typedef enum logic [2:0] {
        PH_HDR0 = 3'd0,
        PH_HDR1 = 3'd1,
        PH_EXT  = 3'd2,
        PH_KEY  = 3'd3,
        PH_DATA = 3'd4,
        PH_HALT = 3'd5
    } phase_t;

    // one classified item waiting for the back end
    typedef struct packed {
        event_t           ev;
        logic [3:0]       opcode;
        logic [7:0]       rx_byte;
        logic [7:0]       key_byte;
        logic             last;
        logic [LEN_W-1:0] length;
    } qentry_t;

    // queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

endpackage

// ===== rtl/wsdf_ifs.sv =====
// Valid/ready channel interfaces: received bytes in, deframed results out.
// Depends on wsdf_pkg for the field widths.
interface wsdf_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface wsdf_tx_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                event_res;
    logic [3:0]                frame_opcode_out;
    logic [7:0]                payload_byte;
    logic                      last;
    logic [wsdf_pkg::LEN_W-1:0] frame_length;

    modport source (output valid, output event_res, output frame_opcode_out,
                    output payload_byte, output last, output frame_length,
                    input ready);
    modport sink (input valid, input event_res, input frame_opcode_out,
                  input payload_byte, input last, input frame_length,
                  output ready);
endinterface

// ===== rtl/wsdf_queue.sv =====
// Small FIFO of classified items between the parser front end and the back end.
// Depends on wsdf_pkg.
module wsdf_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  wsdf_pkg::qentry_t din,
    input  logic              pop,
    output wsdf_pkg::qentry_t dout,
    output wsdf_pkg::qstat_t  stat
);
    import wsdf_pkg::*;

    qentry_t           mem [QDEPTH];
    logic [QPTR_W-1:0] wptr_reg, wptr_next;
    logic [QPTR_W-1:0] rptr_reg, rptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (push)
        begin
            wptr_next = (wptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (pop)
        begin
            rptr_next = (rptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wptr_reg] <= din;
        end
    end

    assign dout       = mem[rptr_reg];
    assign stat.full  = (cnt_reg == QCNT_W'(QDEPTH));
    assign stat.empty = (cnt_reg == '0);

endmodule

// ===== rtl/wsdf_front.sv =====
// Front end: header parser state machine; classifies each received byte.
// Depends on wsdf_pkg and wsdf_ifs; pushes results into wsdf_queue.
module wsdf_front #(
    parameter int LENGTH_COUNT_BITS = 17
) (
    input  logic                       clk,
    input  logic                       rst_n,
    wsdf_rx_if.sink                    rx,
    input  logic                       cfg_wr_en,
    input  logic [wsdf_pkg::LEN_W-1:0] cfg_wr_data,
    input  wsdf_pkg::qstat_t           qstat,
    output logic                       q_push,
    output wsdf_pkg::qentry_t          q_entry
);
    import wsdf_pkg::*;

    // payload index never needs more bits than the length cap allows
    localparam int IDX_W = (LENGTH_COUNT_BITS < LEN_W) ? LENGTH_COUNT_BITS : LEN_W;
    localparam logic [LEN_W-1:0] CAP = (LENGTH_COUNT_BITS >= LEN_W) ? '1 :
        LEN_W'((33'd1 << LENGTH_COUNT_BITS) - 33'd1);

    phase_t           state_reg, state_next;
    logic [3:0]       opc_reg, opc_next;
    logic             mask_reg, mask_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic             big_reg, big_next;   // length bits above LEN_W seen
    logic [2:0]       cnt_reg, cnt_next;
    logic [31:0]      key_reg, key_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [LEN_W-1:0] maxp_reg;

    logic             accept;
    logic [LEN_W-1:0] lim;
    logic             chk_len, start_pay, cur_mask, cur_big, fin;
    logic [LEN_W-1:0] cur_len;
    logic [LEN_W:0]   idx_inc;
    logic [7:0]       key_sel;

    assign rx.ready = !qstat.full;
    assign accept   = rx.valid && rx.ready;
    assign lim      = (maxp_reg > CAP) ? CAP : maxp_reg;
    assign idx_inc  = (LEN_W + 1)'(idx_reg) + 1'b1;
    assign fin      = (idx_inc == {1'b0, len_reg});

    always_comb
    begin
        unique case (idx_reg[1:0])
            2'd0:    key_sel = key_reg[31:24];
            2'd1:    key_sel = key_reg[23:16];
            2'd2:    key_sel = key_reg[15:8];
            default: key_sel = key_reg[7:0];
        endcase
        if (!mask_reg)
        begin
            key_sel = 8'h00;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        opc_next   = opc_reg;
        mask_next  = mask_reg;
        len_next   = len_reg;
        big_next   = big_reg;
        cnt_next   = cnt_reg;
        key_next   = key_reg;
        idx_next   = idx_reg;
        chk_len    = 1'b0;
        start_pay  = 1'b0;
        cur_len    = len_reg;
        cur_big    = big_reg;
        cur_mask   = mask_reg;
        q_push     = 1'b0;
        q_entry    = '{ev: EV_DATA, opcode: opc_reg, rx_byte: rx.rx_byte,
                       key_byte: key_sel, last: 1'b1, length: len_reg};

        if (accept)
        begin
            unique case (state_reg)
                PH_HDR0:
                begin
                    opc_next   = rx.rx_byte[3:0];
                    state_next = PH_HDR1;
                end
                PH_HDR1:
                begin
                    mask_next = rx.rx_byte[7];
                    len_next  = '0;
                    big_next  = 1'b0;
                    if (rx.rx_byte[6:0] == LEN7_EXT16)
                    begin
                        cnt_next   = 3'd1;
                        state_next = PH_EXT;
                    end
                    else if (rx.rx_byte[6:0] == LEN7_EXT64)
                    begin
                        cnt_next   = 3'd7;
                        state_next = PH_EXT;
                    end
                    else
                    begin
                        chk_len  = 1'b1;
                        cur_len  = LEN_W'(rx.rx_byte[6:0]);
                        cur_big  = 1'b0;
                        cur_mask = rx.rx_byte[7];
                    end
                end
                PH_EXT:
                begin
                    cur_len  = {len_reg[LEN_W-9:0], rx.rx_byte};
                    cur_big  = big_reg || (len_reg[LEN_W-1:LEN_W-8] != '0);
                    len_next = cur_len;
                    big_next = cur_big;
                    if (cnt_reg == '0)
                    begin
                        chk_len = 1'b1;
                    end
                    else
                    begin
                        cnt_next = cnt_reg - 1'b1;
                    end
                end
                PH_KEY:
                begin
                    key_next = {key_reg[23:0], rx.rx_byte};
                    if (cnt_reg == '0)
                    begin
                        start_pay = 1'b1;
                    end
                    else
                    begin
                        cnt_next = cnt_reg - 1'b1;
                    end
                end
                PH_DATA:
                begin
                    idx_next = idx_inc[IDX_W-1:0];
                    if (opc_reg == OPC_CLOSE)
                    begin
                        if (fin)
                        begin
                            q_push        = 1'b1;
                            q_entry.ev    = EV_CLOSE;
                            q_entry.rx_byte  = 8'h00;
                            q_entry.key_byte = 8'h00;
                            state_next    = PH_HALT;
                        end
                    end
                    else
                    begin
                        q_push       = 1'b1;
                        q_entry.last = fin;
                        if (fin)
                        begin
                            state_next = PH_HDR0;
                        end
                    end
                end
                PH_HALT:
                begin
                    state_next = PH_HALT;
                end
                default:
                begin
                    state_next = PH_HALT;
                end
            endcase

            // length complete: limit check before any key byte
            if (chk_len)
            begin
                len_next = cur_len;
                if (cur_big || (cur_len > lim))
                begin
                    q_push           = 1'b1;
                    q_entry.ev       = EV_ERROR;
                    q_entry.rx_byte  = 8'h00;
                    q_entry.key_byte = 8'h00;
                    q_entry.length   = cur_big ? '1 : cur_len;
                    state_next       = PH_HALT;
                end
                else if (cur_mask)
                begin
                    state_next = PH_KEY;
                    cnt_next   = 3'd3;
                    key_next   = '0;
                end
                else
                begin
                    key_next  = '0;
                    start_pay = 1'b1;
                end
            end

            if (start_pay)
            begin
                idx_next = '0;
                if (len_next == '0)
                begin
                    q_push           = 1'b1;
                    q_entry.rx_byte  = 8'h00;
                    q_entry.key_byte = 8'h00;
                    q_entry.length   = '0;
                    if (opc_reg == OPC_CLOSE)
                    begin
                        q_entry.ev = EV_CLOSE;
                        state_next = PH_HALT;
                    end
                    else
                    begin
                        q_entry.ev = EV_EMPTY;
                        state_next = PH_HDR0;
                    end
                end
                else
                begin
                    state_next = PH_DATA;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= PH_HDR0;
            opc_reg   <= '0;
            mask_reg  <= 1'b0;
            len_reg   <= '0;
            big_reg   <= 1'b0;
            cnt_reg   <= '0;
            key_reg   <= '0;
            idx_reg   <= '0;
            maxp_reg  <= MAX_PAYLOAD_RST;
        end
        else
        begin
            state_reg <= state_next;
            opc_reg   <= opc_next;
            mask_reg  <= mask_next;
            len_reg   <= len_next;
            big_reg   <= big_next;
            cnt_reg   <= cnt_next;
            key_reg   <= key_next;
            idx_reg   <= idx_next;
            if (cfg_wr_en)
            begin
                maxp_reg <= cfg_wr_data;
            end
        end
    end

endmodule

// ===== rtl/wsdf_back.sv =====
// Back end: unmasks queued items and holds them in the output register.
// Depends on wsdf_pkg and wsdf_ifs; drains wsdf_queue.
module wsdf_back (
    input  logic              clk,
    input  logic              rst_n,
    input  wsdf_pkg::qstat_t  qstat,
    input  wsdf_pkg::qentry_t q_head,
    output logic              q_pop,
    wsdf_tx_if.source         tx
);
    import wsdf_pkg::*;

    logic             valid_reg, valid_next;
    logic [1:0]       ev_reg;
    logic [3:0]       opc_reg;
    logic [7:0]       byte_reg;
    logic             last_reg;
    logic [LEN_W-1:0] len_reg;

    assign q_pop = !qstat.empty && (!valid_reg || tx.ready);

    always_comb
    begin
        valid_next = valid_reg;
        if (q_pop)
        begin
            valid_next = 1'b1;
        end
        else if (tx.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            ev_reg   <= q_head.ev;
            opc_reg  <= q_head.opcode;
            byte_reg <= q_head.rx_byte ^ q_head.key_byte;
            last_reg <= q_head.last;
            len_reg  <= q_head.length;
        end
    end

    assign tx.valid            = valid_reg;
    assign tx.event_res        = ev_reg;
    assign tx.frame_opcode_out = opc_reg;
    assign tx.payload_byte     = byte_reg;
    assign tx.last             = last_reg;
    assign tx.frame_length     = len_reg;

endmodule

// ===== rtl/websocket_frame_deframer_top.sv =====
// WebSocket frame deframer, top level. Takes one received byte per cycle
// on rx, parses the frame header (opcode, mask flag, 7-bit / 16-bit /
// 64-bit length, optional 4-byte mask key) and gives each payload byte
// unmasked on tx, tagged with opcode and frame length, with last marking
// the final byte. Empty non-close frames give one empty-end item; a close
// frame swallows its payload and gives one close item; a length above
// min(max_payload, 2^LENGTH_COUNT_BITS - 1) gives one error item. After a
// close or error item the block keeps taking bytes but drops them until
// rst_n. Rate: one byte per cycle sustained while tx is ready, header
// bytes included; a result passes the queue and the output register
// before it shows on tx. The front-end parser state machine handles each
// byte as it is taken; a two-item queue decouples it from the output
// register, so tx back-pressure only stalls rx once the queue fills.
// Depends on wsdf_pkg, wsdf_ifs, wsdf_queue, wsdf_front, wsdf_back.
module websocket_frame_deframer_top #(
    parameter int LENGTH_COUNT_BITS = 17
) (
    input  logic                       clk,
    input  logic                       rst_n,
    wsdf_rx_if.sink                    rx,
    wsdf_tx_if.source                  tx,
    input  logic                       cfg_wr_en,
    input  logic [wsdf_pkg::LEN_W-1:0] cfg_wr_data
);
    import wsdf_pkg::*;

    qentry_t q_in;     // classified item from the parser
    qentry_t q_head;   // oldest queued item
    qstat_t  qstat;
    logic    q_push;
    logic    q_pop;

    // front end: header parsing, length check, mask key capture
    wsdf_front #(
        .LENGTH_COUNT_BITS(LENGTH_COUNT_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .qstat      (qstat),
        .q_push     (q_push),
        .q_entry    (q_in)
    );

    // decoupling queue
    wsdf_queue u_queue (
        .clk  (clk),
        .rst_n(rst_n),
        .push (q_push),
        .din  (q_in),
        .pop  (q_pop),
        .dout (q_head),
        .stat (qstat)
    );

    // back end: unmask and present on tx
    wsdf_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .qstat (qstat),
        .q_head(q_head),
        .q_pop (q_pop),
        .tx    (tx)
    );

endmodule

// ===== rtl/wsdf_checker.sv =====
// Port-level checks for the deframer top, attached by bind.
// Depends on wsdf_pkg and websocket_frame_deframer_top.
module wsdf_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       tx_valid,
    input logic                       tx_ready,
    input logic [1:0]                 tx_event,
    input logic [3:0]                 tx_opcode,
    input logic [7:0]                 tx_byte,
    input logic                       tx_last,
    input logic [wsdf_pkg::LEN_W-1:0] tx_length
);
    import wsdf_pkg::*;

    // a stalled item holds
    a_tx_hold: assert property (@(posedge clk) disable iff (!rst_n)
        tx_valid && !tx_ready |=> tx_valid && $stable(tx_event) && $stable(tx_byte)
            && $stable(tx_length) && $stable(tx_last))
        else $error("tx item changed while stalled");

    // every non-data item closes its frame
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        tx_valid && (tx_event != EV_DATA) |-> tx_last)
        else $error("non-data item without last");

    // only data items carry a byte
    a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        tx_valid && (tx_event != EV_DATA) |-> (tx_byte == 8'h00))
        else $error("non-data item with payload byte");

    // close items only come from close frames
    a_close_opc: assert property (@(posedge clk) disable iff (!rst_n)
        tx_valid && (tx_event == EV_CLOSE) |-> (tx_opcode == OPC_CLOSE))
        else $error("close item with wrong opcode");

endmodule

bind websocket_frame_deframer_top wsdf_checker u_wsdf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .tx_valid (tx.valid),
    .tx_ready (tx.ready),
    .tx_event (tx.event_res),
    .tx_opcode(tx.frame_opcode_out),
    .tx_byte  (tx.payload_byte),
    .tx_last  (tx.last),
    .tx_length(tx.frame_length)
);

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for websocket_frame_deframer_top: a byte-level predictor,
// random frame traffic with idling, and a halt at the end. Needs wsdf_pkg, wsdf_ifs, RTL.
module tb;
    import wsdf_pkg::*;

    // Length counter width of the block (its parameter is left at default).
    localparam int LEN_CNT_BITS = 17;
    // Cycles to let the output pipeline settle before a register write.
    localparam int DRAIN_CYCLES = 4;
    localparam int END_CYCLES   = 8;
    // Cycles with no item moving on either side before the run is declared hung.
    localparam int HANG_LIMIT   = 2000;

    // How a frame header encodes its payload length.
    typedef enum int { ENC_7, ENC_16, ENC_64 } len_enc_t;

    // One deframed result as seen on tx.
    typedef struct packed {
        event_t           ev;
        logic [3:0]       opc;
        logic [7:0]       data;
        logic             last;
        logic [LEN_W-1:0] flen;
    } deframed_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [LEN_W-1:0] cfg_wr_data;

    wsdf_rx_if rx_ch();
    wsdf_tx_if tx_ch();

    websocket_frame_deframer_top u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx_ch),
        .tx         (tx_ch),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Results still owed by the block, oldest first.
    deframed_t expected_events[$];

    int err_count;
    int bytes_sent;
    int snd_idle_pct;   // chance (of 100) that the sender idles a cycle
    int rcv_stall_pct;  // chance (of 100) that the receiver holds off ready

    // Predictor state: a private copy of the parser.
    phase_t           m_phase;
    logic [3:0]       m_opc;
    logic             m_masked;
    logic [63:0]      m_len;
    logic [2:0]       m_hdr_cnt;
    logic [31:0]      m_key;
    logic [LEN_W-1:0] m_idx;
    logic [LEN_W-1:0] m_max;

    task automatic report_mismatch(input string msg);
        err_count++;
        if (err_count <= 40)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    function automatic void push_result(input event_t ev, input logic [7:0] d,
                                        input logic l, input logic [LEN_W-1:0] fl);
        deframed_t r;
        r.ev   = ev;
        r.opc  = m_opc;
        r.data = d;
        r.last = l;
        r.flen = fl;
        expected_events.push_back(r);
    endfunction

    // Header done (and key, if any): empty frames finish here, others go to data.
    function automatic void start_payload();
        m_idx = '0;
        if (m_len == 64'd0)
        begin
            if (m_opc == OPC_CLOSE)
            begin
                m_phase = PH_HALT;
                push_result(EV_CLOSE, 8'h00, 1'b1, '0);
            end
            else
            begin
                m_phase = PH_HDR0;
                push_result(EV_EMPTY, 8'h00, 1'b1, '0);
            end
        end
        else
            m_phase = PH_DATA;
    endfunction

    // Length known: limit check comes before any key byte.
    function automatic void finish_length();
        logic [63:0]      cap;
        logic [63:0]      lim;
        logic [LEN_W-1:0] sat;
        cap = (64'd1 << LEN_CNT_BITS) - 64'd1;
        lim = {47'd0, m_max};
        if (lim > cap)
            lim = cap;
        if (m_len > lim)
        begin
            sat = (m_len > 64'h1FFFF) ? 17'h1FFFF : m_len[LEN_W-1:0];
            m_phase = PH_HALT;
            push_result(EV_ERROR, 8'h00, 1'b1, sat);
        end
        else if (m_masked)
        begin
            m_phase   = PH_KEY;
            m_hdr_cnt = 3'd3;
            m_key     = '0;
        end
        else
        begin
            m_key = '0;
            start_payload();
        end
    endfunction

    // Advance the predictor by one accepted byte.
    function automatic void deframe_byte(input logic [7:0] b);
        int         kk;
        logic [7:0] v;
        logic       fin;
        case (m_phase)
            PH_HDR0:
            begin
                m_opc   = b[3:0];
                m_phase = PH_HDR1;
            end
            PH_HDR1:
            begin
                m_masked = b[7];
                m_len    = '0;
                if (b[6:0] == LEN7_EXT16)
                begin
                    m_hdr_cnt = 3'd1;
                    m_phase   = PH_EXT;
                end
                else if (b[6:0] == LEN7_EXT64)
                begin
                    m_hdr_cnt = 3'd7;
                    m_phase   = PH_EXT;
                end
                else
                begin
                    m_len = {57'd0, b[6:0]};
                    finish_length();
                end
            end
            PH_EXT:
            begin
                m_len = {m_len[55:0], b};
                if (m_hdr_cnt == 3'd0)
                    finish_length();
                else
                    m_hdr_cnt = m_hdr_cnt - 3'd1;
            end
            PH_KEY:
            begin
                m_key = {m_key[23:0], b};
                if (m_hdr_cnt == 3'd0)
                    start_payload();
                else
                    m_hdr_cnt = m_hdr_cnt - 3'd1;
            end
            PH_DATA:
            begin
                kk = int'(m_idx[1:0]);
                v  = b;
                if (m_masked)
                    v = v ^ m_key[8*(3-kk) +: 8];
                fin   = ({47'd0, m_idx} + 64'd1 == m_len);
                m_idx = m_idx + 1'b1;
                if (m_opc == OPC_CLOSE)
                begin
                    // close payload is swallowed; one close item at its end
                    if (fin)
                    begin
                        m_phase = PH_HALT;
                        push_result(EV_CLOSE, 8'h00, 1'b1, m_len[LEN_W-1:0]);
                    end
                end
                else
                begin
                    if (fin)
                        m_phase = PH_HDR0;
                    push_result(EV_DATA, v, fin, m_len[LEN_W-1:0]);
                end
            end
            default:
            begin
                // halted: bytes are taken and dropped
            end
        endcase
    endfunction

    // Present one byte on rx and hold it until taken. Called and returns at a
    // rising edge; valid stays high so back-to-back items need no toggle.
    // Ready is read at the falling edge, when everything has settled.
    task automatic send_rx_byte(input logic [7:0] b);
        logic taken;
        while ($urandom_range(99) < snd_idle_pct)
        begin
            rx_ch.valid <= 1'b0;
            @(posedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do
        begin
            @(negedge clk);
            taken = rx_ch.ready;
            if (taken)
            begin
                deframe_byte(b);
                bytes_sent++;
            end
            @(posedge clk);
        end
        while (!taken);
    endtask

    // Drop valid and wait until every owed result is out, plus the pipeline.
    task automatic wait_drained();
        rx_ch.valid <= 1'b0;
        while (expected_events.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_max_payload(input logic [LEN_W-1:0] v);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        m_max = v;
    endtask

    function automatic len_enc_t pick_enc(input logic [63:0] len);
        int r;
        r = $urandom_range(99);
        if (len <= 64'd125)
            return (r < 70) ? ENC_7 : ((r < 85) ? ENC_16 : ENC_64);
        if (len <= 64'd65535)
            return (r < 75) ? ENC_16 : ENC_64;
        return ENC_64;
    endfunction

    // One frame on the wire: header with random FIN/RSV bits, length in the
    // chosen encoding, key if masked, then body bytes (fill < 0 means random).
    task automatic send_frame(input logic [3:0] opc, input logic [63:0] len,
                              input logic masked, input len_enc_t enc,
                              input int body, input int fill);
        logic [3:0] flags;
        logic [7:0] rb;
        flags = 4'($urandom_range(15));
        send_rx_byte({flags, opc});
        case (enc)
            ENC_7:
                send_rx_byte({masked, len[6:0]});
            ENC_16:
            begin
                send_rx_byte({masked, LEN7_EXT16});
                send_rx_byte(len[15:8]);
                send_rx_byte(len[7:0]);
            end
            default:
            begin
                send_rx_byte({masked, LEN7_EXT64});
                for (int i = 7; i >= 0; i--)
                    send_rx_byte(len[8*i +: 8]);
            end
        endcase
        if (masked)
            repeat (4) send_rx_byte(8'($urandom_range(255)));
        for (int i = 0; i < body; i++)
        begin
            rb = (fill < 0) ? 8'($urandom_range(255)) : 8'(fill);
            send_rx_byte(rb);
        end
    endtask

    // Well-formed data frames within the current limit until n bytes went out.
    // Lengths are mostly short, with empty frames and frames exactly at a
    // small limit mixed in.
    task automatic random_frames(input int n);
        int          stop_at;
        int          lim;
        int          hi_big;
        int          hi_small;
        int          r;
        logic [3:0]  opc;
        logic [63:0] len;
        stop_at = bytes_sent + n;
        while (bytes_sent < stop_at)
        begin
            lim      = int'(m_max);
            hi_big   = (lim < 300) ? lim : 300;
            hi_small = (lim < 24) ? lim : 24;
            r        = $urandom_range(99);
            if (r < 10)
                len = 64'd0;
            else if (r < 22)
                len = (lim <= 300) ? 64'(lim) : 64'($urandom_range(300, 126));
            else if (r < 30)
                len = 64'($urandom_range(hi_big));
            else
                len = 64'($urandom_range(hi_small));
            do
                opc = 4'($urandom_range(15));
            while (opc == OPC_CLOSE);
            send_frame(opc, len, 1'($urandom_range(1)), pick_enc(len), int'(len), -1);
        end
    endtask

    // Empty frames (plain and masked), a masked ping, each length encoding,
    // payload bytes at both extremes.
    task automatic test_directed();
        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
        send_frame(4'h1, 64'd0, 1'b0, ENC_7, 0, -1);
        send_frame(4'hA, 64'd0, 1'b1, ENC_7, 0, -1);
        send_frame(4'h9, 64'd1, 1'b1, ENC_7, 1, 8'hFF);
        send_frame(4'hF, 64'd1, 1'b0, ENC_16, 1, 8'h00);
        send_frame(4'h0, 64'd0, 1'b0, ENC_64, 0, -1);
    endtask

    // Random traffic in four phases, each under its own limit and its own
    // idle and stall rates. One phase has the sender pause for a full drain.
    task automatic test_random_traffic();
        set_max_payload(17'd1);
        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
        random_frames(190);

        set_max_payload(17'($urandom_range(300, 2)));
        snd_idle_pct  = 72;
        rcv_stall_pct = 0;
        random_frames(190);

        set_max_payload(17'd65535);
        snd_idle_pct  = 0;
        rcv_stall_pct = 72;
        random_frames(95);
        wait_drained();
        random_frames(95);

        set_max_payload(17'd65536);
        snd_idle_pct  = 6;
        rcv_stall_pct = 6;
        random_frames(190);
    endtask

    // Only one halt fits in a run, so the seed picks it: a close frame, a
    // length one over the limit, or a huge 64-bit length that saturates.
    // The bytes after it must all be dropped.
    task automatic test_halt_on_terminal();
        int          mode;
        logic        masked;
        logic [63:0] len;
        set_max_payload(17'($urandom_range(64, 8)));
        mode   = $urandom_range(2);
        masked = 1'($urandom_range(1));
        case (mode)
            0:
            begin
                len = 64'($urandom_range(6));
                send_frame(OPC_CLOSE, len, masked, pick_enc(len), int'(len), -1);
            end
            1:
            begin
                len = {47'd0, m_max} + 64'd1;
                send_frame(4'($urandom_range(7)), len, masked, pick_enc(len), 0, -1);
            end
            default:
            begin
                len = {$urandom, $urandom};
                len[17 + $urandom_range(46)] = 1'b1;
                send_frame(4'h1, len, masked, ENC_64, 0, -1);
            end
        endcase
        repeat (24) send_rx_byte(8'($urandom_range(255)));
    endtask

    // Receiver side: ready drops at random per the current stall rate.
    always @(posedge clk)
        tx_ch.ready <= ($urandom_range(99) >= rcv_stall_pct);

    // Each result taken on tx is checked against the oldest prediction.
    // Sampled at the falling edge; the handshake completes at the next rise.
    always @(negedge clk)
    begin : result_check
        deframed_t want;
        if (rst_n && tx_ch.valid && tx_ch.ready)
        begin
            if (expected_events.size() == 0)
                report_mismatch($sformatf("result with none owed: ev=%0d opc=%0h data=%02h",
                                          tx_ch.event_res, tx_ch.frame_opcode_out,
                                          tx_ch.payload_byte));
            else
            begin
                want = expected_events.pop_front();
                if (tx_ch.event_res !== want.ev)
                    report_mismatch($sformatf("event_res %0d, want %0d",
                                              tx_ch.event_res, want.ev));
                if (tx_ch.frame_opcode_out !== want.opc)
                    report_mismatch($sformatf("frame_opcode_out %0h, want %0h",
                                              tx_ch.frame_opcode_out, want.opc));
                if (tx_ch.payload_byte !== want.data)
                    report_mismatch($sformatf("payload_byte %02h, want %02h",
                                              tx_ch.payload_byte, want.data));
                if (tx_ch.last !== want.last)
                    report_mismatch($sformatf("last %0b, want %0b",
                                              tx_ch.last, want.last));
                if (tx_ch.frame_length !== want.flen)
                    report_mismatch($sformatf("frame_length %0d, want %0d",
                                              tx_ch.frame_length, want.flen));
            end
        end
    end

    // Hang guard: counts cycles in which no item moves on either side.
    always @(negedge clk)
    begin : hang_guard
        int quiet;
        if (rst_n)
        begin
            if ((rx_ch.valid && rx_ch.ready) || (tx_ch.valid && tx_ch.ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= HANG_LIMIT)
            begin
                $display("timeout: no item moved for %0d cycles", HANG_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        err_count     = 0;
        bytes_sent    = 0;
        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
        rx_ch.valid   <= 1'b0;
        rx_ch.rx_byte <= 8'h00;
        cfg_wr_en     <= 1'b0;
        cfg_wr_data   <= '0;
        rst_n         <= 1'b0;

        // predictor reset state
        m_phase   = PH_HDR0;
        m_opc     = '0;
        m_masked  = 1'b0;
        m_len     = '0;
        m_hdr_cnt = '0;
        m_key     = '0;
        m_idx     = '0;
        m_max     = MAX_PAYLOAD_RST;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_traffic();
        test_halt_on_terminal();

        wait_drained();
        repeat (END_CYCLES) @(posedge clk);
        if (err_count == 0 && expected_events.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/wsdf_pkg.sv
rtl/wsdf_ifs.sv
rtl/wsdf_queue.sv
rtl/wsdf_front.sv
rtl/wsdf_back.sv
rtl/websocket_frame_deframer_top.sv
rtl/wsdf_checker.sv
test/tb.sv
